// ===== rtl/srrt_pkg.sv =====
package srrt_pkg;

    localparam int OFS_W = 62;
    localparam int LEN_W = 16;
    localparam int W32 = 32;
    localparam int ENT_W = OFS_W + LEN_W;
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam logic [W32-1:0] BUDGET_RESET = 32'd131072;
    localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [OFS_W-1:0] frame_offset;
        logic [LEN_W-1:0] frame_length;
        logic             frame_fin;
        logic [OFS_W-1:0] delivered_offset;
        logic [W32-1:0]   max_bytes;
    } srrt_req_t;

    typedef struct packed {
        logic             accepted;
        logic             room_exhausted;
        logic [W32-1:0]   extracted_bytes;
        logic [OFS_W-1:0] new_position;
        logic [W32-1:0]   deliverable_bytes;
        logic [W32-1:0]   buffered_bytes;
        logic [OFS_W-1:0] final_size;
        logic             fin_seen;
    } srrt_rsp_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic eval;
        logic cpy;
        logic tail;
        logic commit;
    } srrt_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic split;
    } srrt_sts_t;

endpackage

// ===== rtl/srrt_ram.sv =====
module srrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/srrt_ctrl.sv =====
module srrt_ctrl
    import srrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    input  srrt_sts_t sts,
    output srrt_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_CPY,
        S_TAIL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   vld_reg, vld_next;
    logic   out_free;

    assign out_free  = !vld_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = vld_reg;

    always_comb
    begin
        state_next = state_reg;
        vld_next   = vld_reg && rsp_stall;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.empty ? S_TAIL : S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.split)
                begin
                    state_next = S_CPY;
                end
                else
                begin
                    state_next = sts.last ? S_TAIL : S_RD;
                end
            end
            S_CPY:
            begin
                cmd.cpy    = 1'b1;
                state_next = sts.last ? S_TAIL : S_RD;
            end
            S_TAIL:
            begin
                cmd.tail   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    vld_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

endmodule

// ===== rtl/srrt_dp.sv =====
module srrt_dp
    import srrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  srrt_req_t      req,
    input  srrt_cmd_t      cmd,
    output srrt_sts_t      sts,
    output srrt_rsp_t      rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic           paddr,
    input  logic [W32-1:0] pwdata,
    output logic [W32-1:0] prdata
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [CW-1:0] N_C = CW'(TABLE_ENTRIES);

    logic [W32-1:0]   budget_reg;
    logic             op_reg, op_next;
    logic [OFS_W-1:0] fend_reg, fend_next;
    logic [OFS_W-1:0] start_reg, start_next;
    logic             act_reg, act_next;
    logic [OFS_W-1:0] pos_reg, pos_next;
    logic [W32-1:0]   rem_reg, rem_next;
    logic [W32-1:0]   ext_reg, ext_next;
    logic [W32-1:0]   held_reg, held_next;
    logic [OFS_W-1:0] fsize_reg, fsize_next;
    logic             fin_reg, fin_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    widx_reg, widx_next;
    logic [CW-1:0]    ins_reg, ins_next;
    logic             acc_reg, acc_next;
    logic             exh_reg, exh_next;
    logic [OFS_W-1:0] pc_reg, pc_next;
    logic             cstop_reg, cstop_next;
    logic             bnk_reg, bnk_next;
    srrt_rsp_t        out_reg, out_next;

    logic [ENT_W-1:0] rdata0, rdata1, rd_ent, wdata;
    logic             we;
    logic [OFS_W-1:0] ws, we_e;
    logic [OFS_W-1:0] s, e, pend;
    logic [LEN_W-1:0] l, plen, tlen, trim, usable;
    logic [W32-1:0]   room;
    logic             full, a_live, a_gap, a_fit, t_live, t_fit, x_fit;
    logic [OFS_W:0]   fsum;
    logic [OFS_W-1:0] fend_c;

    srrt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_ram0 (
        .clk   (clk),
        .we    (we && bnk_reg),
        .waddr (widx_reg[IW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd && !bnk_reg),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata0)
    );

    srrt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_ram1 (
        .clk   (clk),
        .we    (we && !bnk_reg),
        .waddr (widx_reg[IW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd && bnk_reg),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata1)
    );

    assign rd_ent = bnk_reg ? rdata1 : rdata0;
    assign s      = rd_ent[ENT_W-1:LEN_W];
    assign l      = rd_ent[LEN_W-1:0];
    assign e      = s + OFS_W'(l);

    assign room   = (held_reg >= budget_reg) ? '0 : (budget_reg - held_reg);
    assign full   = (cnt_reg + ins_reg) >= N_C;

    assign a_live = (op_reg == OP_ADD) && act_reg && (start_reg < fend_reg) && (e > start_reg);
    assign a_gap  = a_live && (s > start_reg);
    assign pend   = (s >= fend_reg) ? fend_reg : s;
    assign plen   = LEN_W'(pend - start_reg);
    assign a_fit  = ({{(W32-LEN_W){1'b0}}, plen} <= room) && !full;

    assign t_live = (op_reg == OP_ADD) && act_reg && (start_reg < fend_reg);
    assign tlen   = LEN_W'(fend_reg - start_reg);
    assign t_fit  = ({{(W32-LEN_W){1'b0}}, tlen} <= room) && !full;

    assign trim   = LEN_W'(pos_reg - s);
    assign usable = l - trim;
    assign x_fit  = {{(W32-LEN_W){1'b0}}, usable} <= rem_reg;

    assign fsum   = {1'b0, req.frame_offset} + (OFS_W + 1)'(req.frame_length);
    assign fend_c = fsum[OFS_W] ? OFS_MAX : fsum[OFS_W-1:0];

    assign sts.empty = (cnt_reg == '0);
    assign sts.last  = (idx_reg == cnt_reg);
    assign sts.split = a_gap && a_fit;

    assign rsp    = out_reg;
    assign prdata = budget_reg;

    always_comb
    begin
        op_next    = op_reg;
        fend_next  = fend_reg;
        start_next = start_reg;
        act_next   = act_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        ext_next   = ext_reg;
        held_next  = held_reg;
        fsize_next = fsize_reg;
        fin_next   = fin_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        widx_next  = widx_reg;
        ins_next   = ins_reg;
        acc_next   = acc_reg;
        exh_next   = exh_reg;
        pc_next    = pc_reg;
        cstop_next = cstop_reg;
        bnk_next   = bnk_reg;
        out_next   = out_reg;
        we         = 1'b0;
        wdata      = rd_ent;
        ws         = s;
        we_e       = e;

        if (cmd.load)
        begin
            op_next    = req.operation;
            fend_next  = fend_c;
            start_next = (req.frame_offset < req.delivered_offset) ?
                         req.delivered_offset : req.frame_offset;
            pos_next   = req.delivered_offset;
            pc_next    = req.delivered_offset;
            rem_next   = req.max_bytes;
            ext_next   = '0;
            idx_next   = '0;
            widx_next  = '0;
            ins_next   = '0;
            acc_next   = 1'b0;
            exh_next   = 1'b0;
            cstop_next = 1'b0;
            if (req.operation == OP_ADD)
            begin
                act_next = (req.frame_length != '0) && (fend_c > req.delivered_offset);
                if ((req.frame_length != '0) && req.frame_fin)
                begin
                    fsize_next = fend_c;
                    fin_next   = 1'b1;
                end
            end
            else
            begin
                act_next = (req.max_bytes != '0);
            end
        end

        if (cmd.rd)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.eval)
        begin
            if (op_reg == OP_ADD)
            begin
                if (a_gap)
                begin
                    if (a_fit)
                    begin
                        we         = 1'b1;
                        wdata      = {start_reg, plen};
                        ws         = start_reg;
                        we_e       = pend;
                        held_next  = held_reg + W32'(plen);
                        ins_next   = ins_reg + 1'b1;
                        acc_next   = 1'b1;
                        start_next = (s < fend_reg) ? e : fend_reg;
                    end
                    else
                    begin
                        exh_next = 1'b1;
                        act_next = 1'b0;
                        we       = 1'b1;
                    end
                end
                else
                begin
                    if (a_live)
                    begin
                        start_next = e;
                    end
                    we = 1'b1;
                end
            end
            else if (act_reg)
            begin
                if (e <= pos_reg)
                begin
                    held_next = held_reg - W32'(l);
                end
                else if ((s > pos_reg) || !x_fit)
                begin
                    act_next = 1'b0;
                    we       = 1'b1;
                end
                else
                begin
                    pos_next  = pos_reg + OFS_W'(usable);
                    pc_next   = pos_reg + OFS_W'(usable);
                    rem_next  = rem_reg - W32'(usable);
                    ext_next  = ext_reg + W32'(usable);
                    held_next = held_reg - W32'(l);
                    act_next  = (rem_reg != W32'(usable));
                end
            end
            else
            begin
                we = 1'b1;
            end
        end

        if (cmd.cpy)
        begin
            we = 1'b1;
        end

        if (cmd.tail && t_live)
        begin
            if (t_fit)
            begin
                we        = 1'b1;
                wdata     = {start_reg, tlen};
                ws        = start_reg;
                we_e      = fend_reg;
                held_next = held_reg + W32'(tlen);
                ins_next  = ins_reg + 1'b1;
                acc_next  = 1'b1;
            end
            else
            begin
                exh_next = 1'b1;
            end
        end

        if (we)
        begin
            widx_next = widx_reg + 1'b1;
            if (!cstop_reg && (we_e > pc_reg))
            begin
                if (ws > pc_reg)
                begin
                    cstop_next = 1'b1;
                end
                else
                begin
                    pc_next = we_e;
                end
            end
        end

        if (cmd.commit)
        begin
            bnk_next                   = !bnk_reg;
            cnt_next                   = widx_reg;
            out_next.accepted          = acc_reg;
            out_next.room_exhausted    = exh_reg;
            out_next.extracted_bytes   = ext_reg;
            out_next.new_position      = pos_reg;
            out_next.deliverable_bytes = W32'(pc_reg - pos_reg);
            out_next.buffered_bytes    = held_reg;
            out_next.final_size        = fsize_reg;
            out_next.fin_seen          = fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
            held_reg   <= '0;
            fsize_reg  <= '0;
            fin_reg    <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            widx_reg   <= '0;
            ins_reg    <= '0;
            bnk_reg    <= 1'b0;
            act_reg    <= 1'b0;
            cstop_reg  <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && (paddr == 1'b0))
            begin
                budget_reg <= pwdata;
            end
            held_reg  <= held_next;
            fsize_reg <= fsize_next;
            fin_reg   <= fin_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            widx_reg  <= widx_next;
            ins_reg   <= ins_next;
            bnk_reg   <= bnk_next;
            act_reg   <= act_next;
            cstop_reg <= cstop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        fend_reg  <= fend_next;
        start_reg <= start_next;
        pos_reg   <= pos_next;
        rem_reg   <= rem_next;
        ext_reg   <= ext_next;
        acc_reg   <= acc_next;
        exh_reg   <= exh_next;
        pc_reg    <= pc_next;
        out_reg   <= out_next;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= N_C)
        else $error("table count above capacity");

    a_widx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> widx_reg < N_C)
        else $error("table write beyond capacity");

    a_widx_total: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> widx_reg <= cnt_reg + ins_reg)
        else $error("rebuilt table larger than old table plus insertions");

    a_commit_swap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> bnk_reg != $past(bnk_reg))
        else $error("bank not swapped on commit");
`endif

endmodule

// ===== rtl/stream_reassembly_range_table.sv =====
// Reassembly range table for one stream: keeps sorted, disjoint received byte
// ranges and answers add and extract requests with one result each. Every
// request rebuilds the table by streaming it from one RAM bank into the other:
// each stored entry is read and then evaluated, a copy step follows for every
// new piece that lands ahead of a stored entry, and a tail step and a commit
// step end the request; each bank RAM has a single read port, and the commit
// waits while the previous result is stalled. A new request is taken while the
// previous result still waits on the output register.
module stream_reassembly_range_table
    import srrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  srrt_req_t      req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output srrt_rsp_t      rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic           paddr,
    input  logic [W32-1:0] pwdata,
    output logic [W32-1:0] prdata,
    output logic           pready
);

    srrt_cmd_t cmd;
    srrt_sts_t sts;

    assign pready = 1'b1;

    srrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    srrt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .cmd     (cmd),
        .sts     (sts),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata)
    );

endmodule
